// File: sv/lse_pkg.sv
`timescale 1ns / 1ps
package lse_pkg;

   // marker bytes, in stream order: 53 53 4E 44
   localparam logic [7:0] MARK_S = 8'h53;
   localparam logic [7:0] MARK_N = 8'h4E;
   localparam logic [7:0] MARK_D = 8'h44;
   localparam logic [2:0] MATCH_FOUND = 3'd4;
   localparam logic [7:0] MARK_LEN = 8'd4;

   localparam logic [7:0] START_OFFSET_RESET = 8'd17;
   localparam logic [3:0] SAMPLE_STRIDE_RESET = 4'd2;

   // configuration register indexes
   localparam logic CSR_START_OFFSET  = 1'b0;
   localparam logic CSR_SAMPLE_STRIDE = 1'b1;

   // result status codes
   localparam logic [1:0] STAT_BYTE    = 2'd0;
   localparam logic [1:0] STAT_TERM    = 2'd1;
   localparam logic [1:0] STAT_UNTERM  = 2'd2;
   localparam logic [1:0] STAT_NOMARK  = 2'd3;

   // token kinds passed from front to back
   localparam logic [1:0] KIND_BIT    = 2'd0;
   localparam logic [1:0] KIND_END    = 2'd1;
   localparam logic [1:0] KIND_NOMARK = 2'd2;

   localparam int TOKQ_DEPTH = 4;
   localparam int TOKQ_AW    = $clog2(TOKQ_DEPTH);
   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_AW    = $clog2(RSPQ_DEPTH);

   typedef struct packed {
      logic [1:0] kind;
      logic       carrier_bit;
      logic       eof;
   } tok_type;

   typedef struct packed {
      logic [7:0] message_byte;
      logic [1:0] status;
      logic       last;
   } rsp_type;

endpackage

// File: sv/lse_front.sv
`timescale 1ns / 1ps
module lse_front import lse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       take,
   input  logic [7:0] data_byte,
   input  logic       end_of_file,
   output logic       tok_push,
   output tok_type    tok
);

   logic [7:0] start_ff, start_in;
   logic [3:0] stride_ff, stride_in;
   logic [2:0] match_ff, match_in;
   logic [7:0] pos_ff, pos_in;
   logic [2:0] match_nx;
   logic [7:0] first_skip;
   logic [7:0] stride_skip;

   function automatic logic [2:0] next_match(input logic [2:0] p, input logic [7:0] b);
      logic [2:0] r;
      r = 3'd0;
      unique case (p)
         3'd0: r = (b == MARK_S) ? 3'd1 : 3'd0;
         3'd1: r = (b == MARK_S) ? 3'd2 : 3'd0;
         3'd2: r = (b == MARK_N) ? 3'd3 : ((b == MARK_S) ? 3'd2 : 3'd0);
         3'd3: r = (b == MARK_D) ? MATCH_FOUND : ((b == MARK_S) ? 3'd1 : 3'd0);
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   assign match_nx    = next_match(match_ff, data_byte);
   // offsets below the marker length clamp to the first byte after it
   assign first_skip  = (start_ff < MARK_LEN) ? 8'd0 : start_ff - MARK_LEN;
   assign stride_skip = (stride_ff == 4'd0) ? 8'd0 : {4'd0, stride_ff} - 8'd1;

   always_comb begin
      start_in  = start_ff;
      stride_in = stride_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_OFFSET:  start_in  = csr_wdata;
            CSR_SAMPLE_STRIDE: stride_in = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      match_in        = match_ff;
      pos_in          = pos_ff;
      tok_push        = 1'b0;
      tok.kind        = KIND_BIT;
      tok.carrier_bit = data_byte[0];
      tok.eof         = end_of_file;
      if (take) begin
         if (match_ff != MATCH_FOUND) begin
            match_in = match_nx;
            if (match_nx == MATCH_FOUND) begin
               pos_in = first_skip;
               if (end_of_file) begin
                  tok_push = 1'b1;
                  tok.kind = KIND_END;
               end
            end else if (end_of_file) begin
               tok_push = 1'b1;
               tok.kind = KIND_NOMARK;
            end
         end else if (pos_ff != 8'd0) begin
            pos_in = pos_ff - 8'd1;
            if (end_of_file) begin
               tok_push = 1'b1;
               tok.kind = KIND_END;
            end
         end else begin
            pos_in   = stride_skip;
            tok_push = 1'b1;
            tok.kind = KIND_BIT;
         end
         if (end_of_file) begin
            match_in = 3'd0;
            pos_in   = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= START_OFFSET_RESET;
         stride_ff <= SAMPLE_STRIDE_RESET;
         match_ff  <= 3'd0;
         pos_ff    <= 8'd0;
      end else begin
         start_ff  <= start_in;
         stride_ff <= stride_in;
         match_ff  <= match_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

// File: sv/lse_tok_queue.sv
`timescale 1ns / 1ps
module lse_tok_queue import lse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  tok_type push_tok,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output tok_type head_tok
);

   tok_type              mem_ff [TOKQ_DEPTH];
   logic [TOKQ_AW-1:0]   wr_ff, wr_in;
   logic [TOKQ_AW-1:0]   rd_ff, rd_in;
   logic [TOKQ_AW:0]     cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign full     = (cnt_ff == (TOKQ_AW+1)'(TOKQ_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_tok = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: sv/lse_back.sv
`timescale 1ns / 1ps
module lse_back import lse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    tok_valid,
   input  tok_type tok,
   output logic    tok_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp
);

   logic [7:0]         acc_ff, acc_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [7:0]         acc_sh;
   logic               gen_valid;
   rsp_type            gen;

   rsp_type            q_ff [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0] qwr_ff, qwr_in;
   logic [RSPQ_AW-1:0] qrd_ff, qrd_in;
   logic [RSPQ_AW:0]   qcnt_ff, qcnt_in;
   logic               q_full, q_push, q_pop;

   assign q_full    = (qcnt_ff == (RSPQ_AW+1)'(RSPQ_DEPTH));
   assign rsp_empty = (qcnt_ff == '0);
   assign rsp       = q_ff[qrd_ff];
   assign q_pop     = rsp_pop && !rsp_empty;
   // take a token whenever the result queue has a slot, even one that yields no result
   assign tok_pop   = tok_valid && (!q_full || q_pop);
   assign acc_sh    = {acc_ff[6:0], tok.carrier_bit};
   assign q_push    = tok_pop && gen_valid;

   always_comb begin
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      done_in   = done_ff;
      gen_valid = 1'b0;
      gen       = '0;
      if (tok_pop) begin
         unique case (tok.kind)
            KIND_BIT: begin
               if (!done_ff) begin
                  if (cnt_ff == 3'd7) begin
                     acc_in    = 8'd0;
                     cnt_in    = 3'd0;
                     gen_valid = 1'b1;
                     if (acc_sh == 8'd0) begin
                        done_in    = 1'b1;
                        gen.status = STAT_TERM;
                        gen.last   = 1'b1;
                     end else if (tok.eof) begin
                        gen.message_byte = acc_sh;
                        gen.status       = STAT_UNTERM;
                        gen.last         = 1'b1;
                     end else begin
                        gen.message_byte = acc_sh;
                        gen.status       = STAT_BYTE;
                     end
                  end else begin
                     acc_in = acc_sh;
                     cnt_in = cnt_ff + 3'd1;
                     if (tok.eof) begin
                        gen_valid  = 1'b1;
                        gen.status = STAT_UNTERM;
                        gen.last   = 1'b1;
                     end
                  end
               end
            end
            KIND_END: begin
               if (!done_ff) begin
                  gen_valid  = 1'b1;
                  gen.status = STAT_UNTERM;
                  gen.last   = 1'b1;
               end
            end
            KIND_NOMARK: begin
               gen_valid  = 1'b1;
               gen.status = STAT_NOMARK;
               gen.last   = 1'b1;
            end
            default: ;
         endcase
         if (tok.eof) begin
            acc_in  = 8'd0;
            cnt_in  = 3'd0;
            done_in = 1'b0;
         end
      end
   end

   always_comb begin
      qwr_in  = q_push ? qwr_ff + 1'b1 : qwr_ff;
      qrd_in  = q_pop  ? qrd_ff + 1'b1 : qrd_ff;
      qcnt_in = qcnt_ff;
      if (q_push && !q_pop) begin
         qcnt_in = qcnt_ff + 1'b1;
      end else if (q_pop && !q_push) begin
         qcnt_in = qcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[qwr_ff] <= gen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= 8'd0;
         cnt_ff  <= 3'd0;
         done_ff <= 1'b0;
         qwr_ff  <= '0;
         qrd_ff  <= '0;
         qcnt_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
         qwr_ff  <= qwr_in;
         qrd_ff  <= qrd_in;
         qcnt_ff <= qcnt_in;
      end
   end

endmodule

// File: sv/lsb_stego_extract.sv
`timescale 1ns / 1ps
// LSB steganography extractor. Push the bytes of a file one word per clock,
// with req_end_of_file high on the final byte. The block finds the first
// marker 53 53 4E 44 (overlapping starts handled), then takes the LSB of the
// byte at start_offset from the marker's first byte and of every
// sample_stride-th byte after it, MSB first, and yields one message byte per
// eight bits. A zero byte ends the message (status 1); a file that ends
// without a marker gives status 3, one that ends mid-message gives status 2,
// and partial bits are dropped. Each file yields status 1, 2 or 3 with
// rsp_last high, except that nothing follows a terminator. Throughput is one
// byte per clock while full is low: the front end (marker match and carrier
// counting) issues at most one token per byte into a 4-entry queue, and the
// back end consumes one token per clock into a 2-entry result queue while it
// has room or is popped. full rises only when results back up behind a held
// pop and the token queue fills. empty falls once a word's result reaches the
// result queue. Write csr_index 0 (start_offset, clamped to at least 4) and 1
// (sample_stride, 0 acts as 1) only while the block is idle.
module lsb_stego_extract import lse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_file,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_message_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   logic    take;
   logic    tok_push;
   tok_type tok_in;
   logic    tok_empty;
   tok_type tok_head;
   logic    tok_pop;
   rsp_type rsp;

   // accept a word whenever the token queue has room
   assign take = push && !full;

   lse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .take        (take),
      .data_byte   (req_data_byte),
      .end_of_file (req_end_of_file),
      .tok_push    (tok_push),
      .tok         (tok_in)
   );

   lse_tok_queue u_tok_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (tok_push),
      .push_tok (tok_in),
      .full     (full),
      .pop      (tok_pop),
      .empty    (tok_empty),
      .head_tok (tok_head)
   );

   lse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (!tok_empty),
      .tok       (tok_head),
      .tok_pop   (tok_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp       (rsp)
   );

   // present the oldest result
   assign rsp_message_byte = rsp.message_byte;
   assign rsp_status       = rsp.status;
   assign rsp_last         = rsp.last;

endmodule
